@@ sv/tdu_pkg.sv @@
package tdu_pkg;

    localparam int TB_W       = 56 + 2;
    localparam int WORD_W     = 32;
    localparam int HI_W       = 24;
    localparam int CYC_W      = 12;
    localparam int OP_W       = 3;
    localparam int SCALE_W    = 21;
    localparam int PROD_W     = CYC_W + SCALE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SCALE_W;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(21'h100000);

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_RD_TB_LO = 3'd1,
        OP_RD_TB_HI = 3'd2,
        OP_WR_TB_LO = 3'd3,
        OP_WR_TB_HI = 3'd4,
        OP_RD_DEC   = 3'd5,
        OP_WR_DEC   = 3'd6
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CYCLE_SCALE = 2'd0,
        CFG_DEC_ENABLE  = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] write_data;
        logic [CYC_W-1:0]  cycles;
        logic [OP_W-1:0]   operation;
    } item_t;

    typedef struct packed {
        logic              dec_underflow;
        logic [WORD_W-1:0] read_data;
    } result_t;

endpackage

@@ sv/tdu_core.sv @@
module tdu_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            exec,
    input  tdu_pkg::item_t                  item,
    input  logic [tdu_pkg::SCALE_W-1:0]     cycle_scale,
    input  logic                            dec_enable,
    output tdu_pkg::result_t                result
);

    logic [tdu_pkg::TB_W-1:0]   tb_reg;
    logic [tdu_pkg::TB_W-1:0]   tb_next;
    logic [tdu_pkg::WORD_W-1:0] dec_reg;
    logic [tdu_pkg::WORD_W-1:0] dec_next;

    logic [tdu_pkg::PROD_W-1:0] scaled;
    logic [tdu_pkg::TB_W-1:0]   tb_sum;
    logic [tdu_pkg::WORD_W-1:0] amount;
    logic [tdu_pkg::WORD_W:0]   dec_diff;

    assign scaled   = tdu_pkg::PROD_W'(item.cycles) * tdu_pkg::PROD_W'(cycle_scale);
    assign tb_sum   = tb_reg + tdu_pkg::TB_W'(scaled);
    // round the decrement up when the new timebase sits between whole ticks
    assign amount   = tdu_pkg::WORD_W'(scaled >> 2)
                    + tdu_pkg::WORD_W'(tb_sum[1:0] != 2'b00);
    assign dec_diff = {1'b0, dec_reg} - {1'b0, amount};

    always_comb begin
        tb_next          = tb_reg;
        dec_next         = dec_reg;
        result.read_data = '0;
        result.dec_underflow = 1'b0;
        unique case (tdu_pkg::op_t'(item.operation))
            tdu_pkg::OP_TICK: begin
                tb_next = tb_sum;
                if (dec_enable) begin
                    dec_next             = dec_diff[tdu_pkg::WORD_W-1:0];
                    result.dec_underflow = dec_diff[tdu_pkg::WORD_W];
                end
            end
            tdu_pkg::OP_RD_TB_LO: begin
                result.read_data = tb_reg[tdu_pkg::WORD_W+1:2];
            end
            tdu_pkg::OP_RD_TB_HI: begin
                result.read_data = tdu_pkg::WORD_W'(tb_reg[tdu_pkg::TB_W-1:tdu_pkg::WORD_W+2]);
            end
            tdu_pkg::OP_WR_TB_LO: begin
                tb_next[tdu_pkg::WORD_W+1:2] = item.write_data;
            end
            tdu_pkg::OP_WR_TB_HI: begin
                tb_next[tdu_pkg::TB_W-1:tdu_pkg::WORD_W+2] = item.write_data[tdu_pkg::HI_W-1:0];
            end
            tdu_pkg::OP_RD_DEC: begin
                result.read_data = dec_reg;
            end
            tdu_pkg::OP_WR_DEC: begin
                dec_next = item.write_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_reg  <= '0;
            dec_reg <= '0;
        end else if (exec) begin
            tb_reg  <= tb_next;
            dec_reg <= dec_next;
        end
    end

endmodule

@@ sv/timebase_decrementer_unit_top.sv @@
// Flow: an accepted request waits in the input register, then moves into the
// result register and raises m_tvalid once that register is empty or draining.
// Throughput: one request per cycle while m_tready keeps the result draining;
// the timebase multiply-add and the decrementer subtract sit in the single
// stage between the two registers.
// Reset: synchronous, active low; timebase and decrementer clear to zero,
// cycle_scale returns to 0x100000 and dec_enable to 1.
module timebase_decrementer_unit_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tdu_pkg::S_TDATA_W-1:0]      s_tdata,  // operation, cycles, write_data, pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tdu_pkg::M_TDATA_W-1:0]      m_tdata,  // read_data, dec_underflow, pad
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tdu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                          in_valid_reg;
    tdu_pkg::item_t                in_item_reg;
    logic                          out_valid_reg;
    tdu_pkg::result_t              out_result_reg;
    logic [tdu_pkg::SCALE_W-1:0]   scale_reg;
    logic                          dec_en_reg;

    logic                          advance;
    tdu_pkg::result_t              core_result;

    // move the held request into the result register when it is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdu_pkg::M_TDATA_W'(out_result_reg);

    tdu_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .exec        (advance),
        .item        (in_item_reg),
        .cycle_scale (scale_reg),
        .dec_enable  (dec_en_reg),
        .result      (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= tdu_pkg::item_t'(s_tdata[$bits(tdu_pkg::item_t)-1:0]);
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= tdu_pkg::SCALE_RESET;
            dec_en_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (tdu_pkg::cfg_idx_t'(cfg_index))
                tdu_pkg::CFG_CYCLE_SCALE: scale_reg  <= cfg_data;
                tdu_pkg::CFG_DEC_ENABLE:  dec_en_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule
